>>> design/assert_macros.svh
// Assertion macros shared by the meter information frame parser RTL.
// Needs nothing else; each file that asserts includes it once.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

`endif

>>> design/mifp_pkg.sv
// Package of the meter information frame parser: widths, character codes,
// result codes and the control and status structs. Depends on nothing.
`timescale 1ns / 1ps

package mifp_pkg;

    localparam int unsigned CHAR_W  = 7;
    localparam int unsigned COUNT_W = 10;
    localparam int unsigned POS_W   = 5;
    localparam int unsigned SUM_W   = 8;
    localparam int unsigned VALUE_W = 30;

    // Control characters and the characters that the parser looks at.
    localparam logic [CHAR_W-1:0] CH_STX   = 7'h02;
    localparam logic [CHAR_W-1:0] CH_ETX   = 7'h03;
    localparam logic [CHAR_W-1:0] CH_LF    = 7'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 7'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 7'h39;
    localparam logic [CHAR_W-1:0] CH_UC_A  = 7'h41;
    localparam logic [CHAR_W-1:0] CH_UC_C  = 7'h43;
    localparam logic [CHAR_W-1:0] CH_UC_H  = 7'h48;
    localparam logic [CHAR_W-1:0] CH_UC_I  = 7'h49;
    localparam logic [CHAR_W-1:0] CH_UC_P  = 7'h50;

    localparam logic [5:0]        SUM_MASK = 6'h3F;
    localparam logic [CHAR_W-1:0] SUM_BIAS = 7'h20;

    localparam logic [COUNT_W-1:0] MAX_FRAME_RESET = 10'd280;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 10'd1023;
    localparam logic [POS_W-1:0]   POS_MAX         = 5'd31;
    localparam logic [VALUE_W-1:0] VALUE_MAX       = 30'd999999999;

    typedef enum logic [1:0] {
        STATUS_VALUE      = 2'd0,
        STATUS_CSUM_ERR   = 2'd1,
        STATUS_OVERFLOW   = 2'd2,
        STATUS_FRAME_DONE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        LABEL_HCHC  = 2'd0,
        LABEL_HCHP  = 2'd1,
        LABEL_IINST = 2'd2,
        LABEL_PAPP  = 2'd3
    } label_t;

    typedef enum logic [1:0] {
        PHASE_LABEL  = 2'd0,
        PHASE_DIGITS = 2'd1,
        PHASE_DONE   = 2'd2
    } phase_t;

    // Per-character commands from the frame control to the line tracker.
    typedef struct packed {
        logic              clear_line;
        logic              push;
        logic [CHAR_W-1:0] rx_char;
    } line_ctl_t;

    // Line status seen by the frame control when CR arrives.
    typedef struct packed {
        logic               short_line;
        logic               sum_ok;
        logic               label_hit;
        label_t             label_code;
        logic [VALUE_W-1:0] value;
    } line_stat_t;

endpackage

>>> design/mifp_line_tracker.sv
// Line tracker: line position, checksum sum, two-character delay line, label
// characters and the decimal value. Depends on mifp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mifp_line_tracker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mifp_pkg::line_ctl_t  ctl,
    output mifp_pkg::line_stat_t stat
);

    logic [mifp_pkg::POS_W-1:0]   pos_reg,    pos_next;
    logic [mifp_pkg::SUM_W-1:0]   sum_reg,    sum_next;
    logic [mifp_pkg::CHAR_W-1:0]  prev0_reg,  prev0_next;
    logic [mifp_pkg::CHAR_W-1:0]  prev1_reg,  prev1_next;
    logic [mifp_pkg::CHAR_W-1:0]  lab0_reg,   lab0_next;
    logic [mifp_pkg::CHAR_W-1:0]  lab1_reg,   lab1_next;
    logic [mifp_pkg::CHAR_W-1:0]  lab2_reg,   lab2_next;
    mifp_pkg::phase_t             phase_reg,  phase_next;
    logic [mifp_pkg::VALUE_W-1:0] acc_reg,    acc_next;

    logic [mifp_pkg::POS_W-1:0]   base_pos;
    logic [mifp_pkg::SUM_W-1:0]   base_sum;
    logic [mifp_pkg::CHAR_W-1:0]  base_prev0;
    logic [mifp_pkg::CHAR_W-1:0]  base_prev1;
    logic [mifp_pkg::CHAR_W-1:0]  base_lab0;
    logic [mifp_pkg::CHAR_W-1:0]  base_lab1;
    logic [mifp_pkg::CHAR_W-1:0]  base_lab2;
    mifp_pkg::phase_t             base_phase;
    logic [mifp_pkg::VALUE_W-1:0] base_acc;
    logic [mifp_pkg::POS_W-1:0]   commit_idx;
    logic                         is_digit;
    logic [mifp_pkg::VALUE_W+3:0] acc_times_ten;
    logic [mifp_pkg::CHAR_W-1:0]  want_char;

    // A line start wipes the line state before the new character is pushed.
    always_comb begin
        if (ctl.clear_line) begin
            base_pos   = '0;
            base_sum   = '0;
            base_prev0 = '0;
            base_prev1 = '0;
            base_lab0  = '0;
            base_lab1  = '0;
            base_lab2  = '0;
            base_phase = mifp_pkg::PHASE_LABEL;
            base_acc   = '0;
        end else begin
            base_pos   = pos_reg;
            base_sum   = sum_reg;
            base_prev0 = prev0_reg;
            base_prev1 = prev1_reg;
            base_lab0  = lab0_reg;
            base_lab1  = lab1_reg;
            base_lab2  = lab2_reg;
            base_phase = phase_reg;
            base_acc   = acc_reg;
        end
    end

    // The character leaving the delay line is committed to the sum and parser.
    assign commit_idx = base_pos - mifp_pkg::POS_W'(2);
    assign is_digit   = (base_prev1 >= mifp_pkg::CH_ZERO) && (base_prev1 <= mifp_pkg::CH_NINE);
    assign acc_times_ten = {1'b0, base_acc, 3'b000} + {3'b000, base_acc, 1'b0}
                         + (mifp_pkg::VALUE_W + 4)'(base_prev1 - mifp_pkg::CH_ZERO);

    always_comb begin
        pos_next   = base_pos;
        sum_next   = base_sum;
        prev0_next = base_prev0;
        prev1_next = base_prev1;
        lab0_next  = base_lab0;
        lab1_next  = base_lab1;
        lab2_next  = base_lab2;
        phase_next = base_phase;
        acc_next   = base_acc;
        if (ctl.push) begin
            if ((base_pos >= mifp_pkg::POS_W'(2)) && (commit_idx != '0)) begin
                sum_next = base_sum + {1'b0, base_prev1};
                if (commit_idx == mifp_pkg::POS_W'(1)) begin
                    lab0_next = base_prev1;
                end else if (commit_idx == mifp_pkg::POS_W'(2)) begin
                    lab1_next = base_prev1;
                end else if (commit_idx == mifp_pkg::POS_W'(4)) begin
                    lab2_next = base_prev1;
                end
                if (base_phase == mifp_pkg::PHASE_LABEL) begin
                    if (base_prev1 == mifp_pkg::CH_SPACE) begin
                        phase_next = mifp_pkg::PHASE_DIGITS;
                    end
                end else if (base_phase == mifp_pkg::PHASE_DIGITS) begin
                    if (is_digit) begin
                        if (acc_times_ten > {4'd0, mifp_pkg::VALUE_MAX}) begin
                            acc_next = mifp_pkg::VALUE_MAX;
                        end else begin
                            acc_next = acc_times_ten[mifp_pkg::VALUE_W-1:0];
                        end
                    end else begin
                        phase_next = mifp_pkg::PHASE_DONE;
                    end
                end
            end
            prev1_next = base_prev0;
            prev0_next = ctl.rx_char;
            if (base_pos != mifp_pkg::POS_MAX) begin
                pos_next = base_pos + mifp_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            sum_reg   <= '0;
            prev0_reg <= '0;
            prev1_reg <= '0;
            lab0_reg  <= '0;
            lab1_reg  <= '0;
            lab2_reg  <= '0;
            phase_reg <= mifp_pkg::PHASE_LABEL;
            acc_reg   <= '0;
        end else if (ctl.clear_line || ctl.push) begin
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            prev0_reg <= prev0_next;
            prev1_reg <= prev1_next;
            lab0_reg  <= lab0_next;
            lab1_reg  <= lab1_next;
            lab2_reg  <= lab2_next;
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
        end
    end

    // Status toward the frame control, from the state before this character.
    assign want_char = {1'b0, sum_reg[5:0] & mifp_pkg::SUM_MASK} + mifp_pkg::SUM_BIAS;

    always_comb begin
        stat.short_line = pos_reg < mifp_pkg::POS_W'(3);
        stat.sum_ok     = prev0_reg == want_char;
        stat.value      = (phase_reg == mifp_pkg::PHASE_LABEL) ? '0 : acc_reg;
        stat.label_hit  = 1'b1;
        stat.label_code = mifp_pkg::LABEL_HCHC;
        priority if (lab0_reg == mifp_pkg::CH_UC_H && lab2_reg == mifp_pkg::CH_UC_C) begin
            stat.label_code = mifp_pkg::LABEL_HCHC;
        end else if (lab0_reg == mifp_pkg::CH_UC_H && lab2_reg == mifp_pkg::CH_UC_P) begin
            stat.label_code = mifp_pkg::LABEL_HCHP;
        end else if (lab0_reg == mifp_pkg::CH_UC_I && lab1_reg == mifp_pkg::CH_UC_I) begin
            stat.label_code = mifp_pkg::LABEL_IINST;
        end else if (lab0_reg == mifp_pkg::CH_UC_P && lab1_reg == mifp_pkg::CH_UC_A) begin
            stat.label_code = mifp_pkg::LABEL_PAPP;
        end else begin
            stat.label_hit  = 1'b0;
        end
    end

    // A bare line clear leaves an empty line; a push always leaves a character.
    // The decimal value never passes its saturation limit.
    `ASSERT_NEXT(a_clear_empties_line, aclk, aresetn, ctl.clear_line && !ctl.push, pos_reg == '0)
    `ASSERT_NEXT(a_push_fills_line, aclk, aresetn, ctl.push, pos_reg != '0 && prev0_reg == $past(ctl.rx_char))
    `ASSERT_NOW(a_value_saturates, aclk, aresetn, 1'b1, acc_reg <= mifp_pkg::VALUE_MAX)

endmodule

>>> design/meter_info_frame_parser.sv
// Top level of the meter information frame parser: handshakes, frame control,
// overflow count and result register. Depends on mifp_pkg, mifp_line_tracker
// and assert_macros.svh.
//
//   channel   ports                                direction   payload
//   -------   ----------------------------------   ---------   ---------------------------
//   input     s_valid s_ready s_rx_byte            in          one received byte
//   result    m_valid m_ready m_status ...         out         status, label code, value
//   config    cfg_valid cfg_ready cfg_wdata        in          max_frame_chars (10 bits)
//
// A byte is registered on acceptance and processed once the result register
// can take a result; its result is written at the end of the cycle in which it
// is processed, and one byte is taken every cycle unless a result waits untaken.
// The rate is set by the checksum and decimal accumulate step. While a result
// waits untaken in the result register, the stored byte waits too, whether or
// not it gives a result, and the input stalls behind it. Reset (aresetn low at
// a clock edge) leaves the block waiting for STX with max_frame_chars at 280;
// cfg_ready is always high.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module meter_info_frame_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [1:0]  m_label_code,
    output logic [29:0] m_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_wdata
);

    logic                          in_valid_reg;
    logic [mifp_pkg::CHAR_W-1:0]   in_char_reg;
    logic [mifp_pkg::COUNT_W-1:0]  max_reg;
    logic                          in_frame_reg,  in_frame_next;
    logic [mifp_pkg::COUNT_W-1:0]  count_reg,     count_next;
    logic                          m_valid_reg;
    mifp_pkg::status_t             out_status_reg, out_status_next;
    mifp_pkg::label_t              out_label_reg,  out_label_next;
    logic [mifp_pkg::VALUE_W-1:0]  out_value_reg,  out_value_next;
    logic                          out_load;
    logic                          consume;
    logic                          over;
    logic                          csum_err;
    logic                          line_hit;
    mifp_pkg::line_ctl_t           line_ctl;
    mifp_pkg::line_stat_t          line_stat;

    // The stored byte moves on whenever the result register can take a result.
    assign consume   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || consume;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (consume) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_rx_byte[mifp_pkg::CHAR_W-1:0];
        end
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= mifp_pkg::MAX_FRAME_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_reg <= cfg_wdata;
        end
    end

    mifp_line_tracker u_line (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (line_ctl),
        .stat    (line_stat)
    );

    // Frame control: STX hunt, CR check, overflow, frame end and result choice.
    always_comb begin
        in_frame_next      = in_frame_reg;
        count_next         = count_reg;
        line_ctl.clear_line = 1'b0;
        line_ctl.push       = 1'b0;
        line_ctl.rx_char    = in_char_reg;
        out_load           = 1'b0;
        out_status_next    = mifp_pkg::STATUS_VALUE;
        out_label_next     = mifp_pkg::LABEL_HCHC;
        out_value_next     = '0;
        over               = count_reg >= max_reg;
        csum_err           = 1'b0;
        line_hit           = 1'b0;
        if (consume) begin
            if (!in_frame_reg) begin
                if (in_char_reg == mifp_pkg::CH_STX) begin
                    in_frame_next       = 1'b1;
                    count_next          = '0;
                    line_ctl.clear_line = 1'b1;
                end
            end else begin
                if (count_reg != mifp_pkg::COUNT_MAX) begin
                    count_next = count_reg + mifp_pkg::COUNT_W'(1);
                end
                if (in_char_reg == mifp_pkg::CH_CR) begin
                    csum_err = line_stat.short_line || !line_stat.sum_ok;
                    line_hit = line_stat.label_hit;
                end else begin
                    line_ctl.clear_line = in_char_reg == mifp_pkg::CH_LF;
                    line_ctl.push       = 1'b1;
                end
                priority if (csum_err) begin
                    in_frame_next   = 1'b0;
                    out_load        = 1'b1;
                    out_status_next = mifp_pkg::STATUS_CSUM_ERR;
                end else if (over) begin
                    in_frame_next   = 1'b0;
                    out_load        = 1'b1;
                    out_status_next = mifp_pkg::STATUS_OVERFLOW;
                end else if (line_hit) begin
                    out_load        = 1'b1;
                    out_status_next = mifp_pkg::STATUS_VALUE;
                    out_label_next  = line_stat.label_code;
                    out_value_next  = line_stat.value;
                end else if (in_char_reg == mifp_pkg::CH_ETX) begin
                    in_frame_next   = 1'b0;
                    out_load        = 1'b1;
                    out_status_next = mifp_pkg::STATUS_FRAME_DONE;
                end else begin
                    out_load        = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
        end else begin
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
        end
    end

    // Result register; a transaction on the result channel frees it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_status_reg <= out_status_next;
            out_label_reg  <= out_label_next;
            out_value_reg  <= out_value_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = out_status_reg;
    assign m_label_code = out_label_reg;
    assign m_value      = out_value_reg;

    // Any error or frame end drops the frame; a held byte waits unchanged.
    `ASSERT_NEXT(a_end_leaves_frame, aclk, aresetn, out_load && out_status_next != mifp_pkg::STATUS_VALUE, !in_frame_reg)
    `ASSERT_NEXT(a_held_byte_waits, aclk, aresetn, in_valid_reg && !consume, in_valid_reg && $stable(in_char_reg))
    `ASSERT_NOW(a_result_needs_room, aclk, aresetn, out_load, !m_valid_reg || m_ready)

endmodule
